// ===== sv/pgcfr_pkg.sv =====
// Package for the chunk fault resolver: sizes, operation and result codes.
// No dependencies.
package pgcfr_pkg;
   localparam int ChunkDepth = 32;
   localparam int OffsetBits = 32;
   localparam int IdxBits = 5;   // chunk index
   localparam int CntBits = 6;   // holds ChunkDepth
   localparam int LenBits = 33;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_FAULT  = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      RK_INIT       = 3'd0,
      RK_COPY       = 3'd1,
      RK_APPEND_OK  = 3'd2,
      RK_APPEND_REJ = 3'd3,
      RK_FAULT_REJ  = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [IdxBits-1:0]      num;
      logic [OffsetBits-1:0]   off;
      logic [LenBits-1:0]      len;
      logic                    last;
   } result_type;

   // memory port to the start table
   typedef struct packed {
      logic                    we;
      logic [CntBits-1:0]      waddr;
      logic [OffsetBits-1:0]   wdata;
      logic [CntBits-1:0]      raddr;
   } mem_req_type;
endpackage

// ===== sv/pgcfr_start_ram.sv =====
// Start-offset table: one write port, one registered read port.
// Depends on pgcfr_pkg.
module pgcfr_start_ram
   import pgcfr_pkg::*;
(
   input  logic                  clock,
   input  mem_req_type           mem_req,
   output logic [OffsetBits-1:0] rd_data
);
   logic [OffsetBits-1:0] mem [ChunkDepth+1];
   logic [OffsetBits-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem[mem_req.raddr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== sv/page_grouped_chunk_fault_resolver_core.sv =====
// Chunk fault resolver core. One item is worked at a time. An append is accepted,
// writing the start entry, then writes the new end entry in S_APP. A clear is done
// when it is accepted. A fault is accepted, then runs binary-search steps (up to 5
// with 32 chunks) and a closing check in S_SRCH. Widening the range reads chunk
// starts downward and chunk ends upward. Each chunk in the range then reads its
// start and end entries and emits an init request if it is not yet resolved,
// and the copy range closes the item. All table reads go through the registered-read
// start-offset RAM. A result waits in the output register while rsp_tready is
// low; the sequencer then stalls when it has the next result ready, and takes no new item.
// Depends on pgcfr_pkg and pgcfr_start_ram.
module page_grouped_chunk_fault_resolver_core
   import pgcfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata,       // page_shift
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,       // operation[1:0]
   input  logic [63:0] req_tdata,       // append size[31:0], fault offset[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,       // result_kind[2:0]
   output logic [71:0] rsp_tdata,       // chunk_number[4:0], byte_offset[36:5],
                                        // byte_length[69:37], zero[71:70]
   output logic        rsp_tlast
);
   typedef enum logic [3:0] {
      S_IDLE, S_APP, S_SRCH, S_SRCHW, S_LO0, S_LOW, S_HI0, S_HIW,
      S_EM0, S_EMW, S_EMW2, S_COPY, S_PUSH
   } state_type;

   state_type               state_ff, state_in;
   logic [4:0]              shift_ff;
   logic [CntBits-1:0]      count_ff, count_in;
   logic [OffsetBits-1:0]   total_ff, total_in;
   logic [ChunkDepth-1:0]   marks_ff, marks_in;
   logic [OffsetBits-1:0]   foff_ff, foff_in;
   logic [CntBits-1:0]      lo_ff, lo_in, hi_ff, hi_in, idx_ff, idx_in;
   logic [OffsetBits:0]     plo_ff, plo_in, phi_ff, phi_in;
   logic [OffsetBits-1:0]   cur_ff, cur_in;
   result_type              res_ff, res_in, pend_ff, pend_in;
   logic                    rvalid_ff, rvalid_in;
   mem_req_type             mem_req;
   logic [OffsetBits-1:0]   rd;
   logic [4:0]              sh_eff;
   logic [OffsetBits:0]     page_lo;
   logic [OffsetBits:0]     sum_w;
   logic [CntBits-1:0]      mid;
   logic                    app_ok;
   logic                    busy_out;

   pgcfr_start_ram u_ram (.clock(clock), .mem_req(mem_req), .rd_data(rd));

   // effective page shift saturates to 9..16
   always_comb begin
      if (shift_ff < 5'd9) sh_eff = 5'd9;
      else if (shift_ff > 5'd16) sh_eff = 5'd16;
      else sh_eff = shift_ff;
   end
   // offset-within-page bits
   assign page_lo = ((OffsetBits+1)'(1) << sh_eff) - (OffsetBits+1)'(1);

   assign sum_w  = {1'b0, total_ff} + {1'b0, req_tdata[31:0]};
   assign app_ok = (req_tdata[31:0] != '0) && !sum_w[OffsetBits]
                   && (count_ff < CntBits'(ChunkDepth));
   // hi stays below 32, so the sum fits the count width
   assign mid = (lo_ff + hi_ff + CntBits'(1)) >> 1;

   assign busy_out   = rvalid_ff && !rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && !busy_out;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      total_in  = total_ff;
      marks_in  = marks_ff;
      foff_in   = foff_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      idx_in    = idx_ff;
      plo_in    = plo_ff;
      phi_in    = phi_ff;
      cur_in    = cur_ff;
      res_in    = res_ff;
      pend_in   = pend_ff;
      rvalid_in = rvalid_ff;
      mem_req   = '0;
      if (rvalid_ff && rsp_tready) rvalid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               foff_in = req_tdata[63:32];
               case (op_type'(req_tuser))
                  OP_APPEND: begin
                     rvalid_in = 1'b1;
                     if (app_ok) begin
                        res_in = '{RK_APPEND_OK, count_ff[IdxBits-1:0], total_ff,
                                   {1'b0, req_tdata[31:0]}, 1'b1};
                        marks_in[count_ff[IdxBits-1:0]] = 1'b0;
                        count_in = count_ff + CntBits'(1);
                        total_in = sum_w[OffsetBits-1:0];
                        mem_req.we    = 1'b1;
                        mem_req.waddr = count_ff;
                        mem_req.wdata = total_ff;
                        state_in = S_APP;
                     end else begin
                        res_in = '{RK_APPEND_REJ, '0, '0, '0, 1'b1};
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                     marks_in = '0;
                  end
                  OP_FAULT: begin
                     if (count_ff == '0) begin
                        rvalid_in = 1'b1;
                        res_in = '{RK_FAULT_REJ, '0, '0, '0, 1'b1};
                     end else begin
                        lo_in = '0;
                        hi_in = count_ff - CntBits'(1);
                        state_in = S_SRCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_APP: begin
            // count and total already bumped: this writes the new end entry
            mem_req.we    = 1'b1;
            mem_req.waddr = count_ff;
            mem_req.wdata = total_ff;
            state_in = S_IDLE;
         end
         S_SRCH: begin
            if (lo_ff == hi_ff) begin
               state_in = S_LO0;
            end else begin
               mem_req.raddr = mid;
               idx_in = mid;
               state_in = S_SRCHW;
            end
         end
         S_SRCHW: begin
            if (rd <= foff_ff) lo_in = idx_ff;
            else hi_in = idx_ff - CntBits'(1);
            state_in = S_SRCH;
         end
         S_LO0: begin
            mem_req.raddr = lo_ff;
            state_in = S_LOW;
         end
         S_LOW: begin
            // walk down while the chunk start is off a page boundary
            if (lo_ff != '0 && ({1'b0, rd} & page_lo) != '0) begin
               lo_in = lo_ff - CntBits'(1);
               state_in = S_LO0;
            end else begin
               plo_in = {1'b0, rd} & ~page_lo;
               state_in = S_HI0;
            end
         end
         S_HI0: begin
            mem_req.raddr = hi_ff + CntBits'(1);
            state_in = S_HIW;
         end
         S_HIW: begin
            if (hi_ff + CntBits'(1) < count_ff && ({1'b0, rd} & page_lo) != '0) begin
               hi_in = hi_ff + CntBits'(1);
               state_in = S_HI0;
            end else begin
               phi_in = ({1'b0, rd} + page_lo) & ~page_lo;
               idx_in = lo_ff;
               state_in = S_EM0;
            end
         end
         S_EM0: begin
            mem_req.raddr = idx_ff;
            state_in = S_EMW;
         end
         S_EMW: begin
            mem_req.raddr = idx_ff + CntBits'(1);
            cur_in = rd;
            state_in = S_EMW2;
         end
         S_EMW2: begin
            if (!marks_ff[idx_ff[IdxBits-1:0]]) begin
               marks_in[idx_ff[IdxBits-1:0]] = 1'b1;
               pend_in = '{RK_INIT, idx_ff[IdxBits-1:0], cur_ff,
                           {1'b0, rd - cur_ff}, 1'b0};
               state_in = S_PUSH;
            end else begin
               state_in = S_COPY;
            end
         end
         S_PUSH: begin
            if (!busy_out) begin
               rvalid_in = 1'b1;
               res_in = pend_ff;
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            if (idx_ff != hi_ff) begin
               idx_in = idx_ff + CntBits'(1);
               state_in = S_EM0;
            end else if (!busy_out) begin
               rvalid_in = 1'b1;
               res_in = '{RK_COPY, '0, plo_ff[OffsetBits-1:0], phi_ff - plo_ff, 1'b1};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         shift_ff  <= 5'd12;
         count_ff  <= '0;
         total_ff  <= '0;
         marks_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (csr_we) shift_ff <= csr_wdata;
         state_ff  <= state_in;
         count_ff  <= count_in;
         total_ff  <= total_in;
         marks_ff  <= marks_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      foff_ff <= foff_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      idx_ff  <= idx_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      cur_ff  <= cur_in;
      res_ff  <= res_in;
      pend_ff <= pend_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tlast  = res_ff.last;
   assign rsp_tdata  = {2'b00, res_ff.len, res_ff.off, res_ff.num};

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntBits'(ChunkDepth)) else $error("count overflow");
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser)
      && $stable(rsp_tlast)) else $error("result changed while waiting");
`endif
endmodule

// ===== sim/tb_page_grouped_chunk_fault_resolver_core.sv =====
// Self-checking bench for page_grouped_chunk_fault_resolver_core: random chunk
// layouts and faults, results predicted in-bench and checked in order.
// Depends on pgcfr_pkg and the core RTL.
module tb_page_grouped_chunk_fault_resolver_core;
   import pgcfr_pkg::*;

   typedef struct {
      kind_type    kind;
      logic [4:0]  num;
      logic [31:0] off;
      logic [32:0] len;
      logic        last;
   } resp_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [4:0]  csr_wdata = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [1:0]  req_tuser = 0;
   logic [63:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [2:0]  rsp_tuser;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;

   page_grouped_chunk_fault_resolver_core DUT (.*);

   always #2 clock = ~clock;

   // bench copy of the block state
   logic [4:0]  page_shift_q = 5'd12;
   logic [32:0] starts [0:ChunkDepth];
   int          n_chunks = 0;
   logic [32:0] total_q = 0;
   bit          resolved [0:ChunkDepth-1];

   logic [65:0] pending_items [$];
   resp_type    expected_resps [$];
   int          errors = 0;
   int          cyc = 0;
   int          stall_cnt = 0;
   bit          took_item = 0;
   logic [4:0]  shifts [6] = '{5'd9, 5'd16, 5'd0, 5'd31, 5'd13, 5'd11};

   task automatic report_mismatch(input string what, input logic [32:0] got,
                                  input logic [32:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cyc);
      errors++;
   endtask

   task automatic expect_resp(input kind_type k, input int num, input logic [31:0] off,
                              input logic [32:0] len, input bit last);
      resp_type r;
      r.kind = k; r.num = num[4:0]; r.off = off; r.len = len; r.last = last;
      expected_resps.push_back(r);
   endtask

   function automatic logic [33:0] pg_trunc(input logic [33:0] x, input int sh);
      return (x >> sh) << sh;
   endfunction

   task automatic predict_resolver(input logic [65:0] item);
      op_type      op;
      logic [32:0] size, sum;
      logic [31:0] fault_addr;
      logic [33:0] plo, phi;
      int          sh, lo, hi, mid;
      op = op_type'(item[1:0]);
      size = {1'b0, item[33:2]};
      fault_addr = item[65:34];
      sh = page_shift_q < 9 ? 9 : page_shift_q > 16 ? 16 : page_shift_q;
      case (op)
         OP_APPEND: begin
            sum = total_q + size;
            if (size == 0 || sum[32] || n_chunks >= ChunkDepth)
               expect_resp(RK_APPEND_REJ, 0, 0, 0, 1);
            else begin
               starts[n_chunks] = total_q;
               starts[n_chunks+1] = sum;
               resolved[n_chunks] = 0;
               expect_resp(RK_APPEND_OK, n_chunks, total_q[31:0], size, 1);
               total_q = sum;
               n_chunks++;
            end
         end
         OP_CLEAR: begin
            n_chunks = 0;
            total_q = 0;
            foreach (resolved[i]) resolved[i] = 0;
         end
         OP_FAULT: begin
            if (n_chunks == 0)
               expect_resp(RK_FAULT_REJ, 0, 0, 0, 1);
            else begin
               lo = 0;
               hi = n_chunks - 1;
               while (lo < hi) begin
                  mid = lo + (hi - lo + 1) / 2;
                  if (starts[mid] <= {1'b0, fault_addr}) lo = mid;
                  else hi = mid - 1;
               end
               hi = lo;
               plo = pg_trunc({1'b0, starts[lo]}, sh);
               phi = pg_trunc({1'b0, starts[hi+1]} + (34'd1 << sh) - 34'd1, sh);
               while (lo > 0 && {1'b0, starts[lo]} > plo) begin
                  lo--;
                  plo = pg_trunc({1'b0, starts[lo]}, sh);
               end
               while (hi + 1 < n_chunks && {1'b0, starts[hi+1]} < phi) begin
                  hi++;
                  phi = pg_trunc({1'b0, starts[hi+1]} + (34'd1 << sh) - 34'd1, sh);
               end
               for (int i = lo; i <= hi; i++)
                  if (!resolved[i]) begin
                     expect_resp(RK_INIT, i, starts[i][31:0], starts[i+1] - starts[i], 0);
                     resolved[i] = 1;
                  end
               expect_resp(RK_COPY, 0, plo[31:0], 33'(phi - plo), 1);
            end
         end
         default: ;   // unused code: no result
      endcase
   endtask

   function automatic bit quiet_window();
      return ((cyc / 1000) % 3) == 1;
   endfunction

   // acceptance and result check at the rising edge
   always @(posedge clock) begin
      resp_type r;
      cyc++;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_resolver({req_tdata, req_tuser});
            took_item = 1;
            stall_cnt = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            stall_cnt = 0;
            if (expected_resps.size() == 0) begin
               report_mismatch("unexpected item", 33'(rsp_tdata[36:5]), 33'd0);
            end else begin
               r = expected_resps.pop_front();
               if (rsp_tuser != r.kind)
                  report_mismatch("kind", 33'(rsp_tuser), 33'(r.kind));
               if (rsp_tdata[4:0] != r.num)
                  report_mismatch("chunk", 33'(rsp_tdata[4:0]), 33'(r.num));
               if (rsp_tdata[36:5] != r.off)
                  report_mismatch("offset", 33'(rsp_tdata[36:5]), 33'(r.off));
               if (rsp_tdata[69:37] != r.len)
                  report_mismatch("length", rsp_tdata[69:37], r.len);
               if (rsp_tdata[71:70] != 2'b00)
                  report_mismatch("padding", 33'(rsp_tdata[71:70]), 33'd0);
               if (rsp_tlast != r.last)
                  report_mismatch("last", 33'(rsp_tlast), 33'(r.last));
            end
         end
      end
   end

   // driver and ready at the falling edge
   always @(negedge clock) begin
      logic [65:0] nxt;
      if (reset) begin
         req_tvalid <= 0;
         rsp_tready <= 0;
      end else begin
         if (!req_tvalid || took_item) begin
            took_item = 0;
            if (pending_items.size() != 0 && (quiet_window() || $urandom_range(99) >= 30)) begin
               nxt = pending_items.pop_front();
               req_tuser <= nxt[1:0];
               req_tdata <= nxt[65:2];
               req_tvalid <= 1;
            end else
               req_tvalid <= 0;
         end
         rsp_tready <= quiet_window() || $urandom_range(99) >= 30;
      end
   end

   // watchdog: no progress while work is outstanding
   always @(posedge clock) begin
      if (!reset && (pending_items.size() != 0 || req_tvalid || expected_resps.size() != 0)) begin
         stall_cnt++;
         if (stall_cnt > 5000) begin
            $display("** page_grouped_chunk_fault_resolver_core: FAILED **");
            $finish;
         end
      end
   end

   task automatic push_item(input op_type op, input logic [31:0] size, input logic [31:0] off);
      pending_items.push_back({off, size, op});
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || req_tvalid || expected_resps.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);   // clears leave no result behind
   endtask

   task automatic write_shift(input logic [4:0] v);
      @(negedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      page_shift_q = v;
   endtask

   // clear, a random layout, then faults into it; returns items queued
   task automatic random_layout(output int n_items);
      int          n, cnt, mode;
      logic [32:0] sum;
      logic [31:0] size, off;
      n_items = 1;
      push_item(OP_CLEAR, $urandom, $urandom);
      n = ($urandom_range(7) == 0) ? 33 : $urandom_range(1, 8);
      cnt = 0;
      sum = 0;
      for (int i = 0; i < n; i++) begin
         mode = $urandom_range(9);
         if (mode < 4) size = $urandom_range(1, 700);
         else if (mode < 7) size = $urandom_range(1, 4) << $urandom_range(9, 16);
         else if (mode < 9) size = $urandom;
         else size = 0;
         push_item(OP_APPEND, size, $urandom);
         n_items++;
         if (size != 0 && sum + size <= 33'hFFFF_FFFF && cnt < ChunkDepth) begin
            sum = sum + size;
            cnt++;
         end
      end
      repeat ($urandom_range(2, 6)) begin
         if ($urandom_range(9) < 8 && sum != 0) off = $urandom % sum[31:0];
         else off = $urandom;
         if ($urandom_range(19) == 0) push_item(OP_NONE, $urandom, $urandom);
         else push_item(OP_FAULT, $urandom, off);
         n_items++;
      end
   endtask

   initial begin
      int count, got;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed, reset page shift
      push_item(OP_FAULT, 0, 0);                        // empty layout
      push_item(OP_APPEND, 0, 0);                       // zero size
      push_item(OP_APPEND, 32'd4096, 32'hFFFF_FFFF);
      push_item(OP_APPEND, 32'd100, 0);
      push_item(OP_APPEND, 32'd5000, 0);
      push_item(OP_APPEND, 32'hFFFF_FFFF, 0);           // overflow
      push_item(OP_FAULT, 0, 32'd4150);
      push_item(OP_FAULT, 0, 0);
      push_item(OP_FAULT, 0, 32'hFFFF_FFFF);            // past the end
      push_item(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_item(OP_CLEAR, 0, 0);
      push_item(OP_FAULT, 0, 32'd10);
      push_item(OP_APPEND, 32'hFFFF_FFFF, 0);           // whole offset space
      push_item(OP_FAULT, 0, 32'hFFFF_FFFE);
      push_item(OP_APPEND, 32'd1, 0);                   // overflow by one
      push_item(OP_CLEAR, 0, 0);
      drain();

      count = 0;
      for (int p = 0; count < 115; p++) begin
         write_shift(p < 6 ? shifts[p] : 5'($urandom));
         for (int k = 0; k < 25 && count < 115; k += got) begin
            random_layout(got);
            count += got;
         end
         drain();
      end

      if (errors == 0)
         $display("** page_grouped_chunk_fault_resolver_core: PASSED **");
      else
         $display("** page_grouped_chunk_fault_resolver_core: FAILED **");
      $finish;
   end
endmodule

// ===== files.f =====
sv/pgcfr_pkg.sv
sv/pgcfr_start_ram.sv
sv/page_grouped_chunk_fault_resolver_core.sv
sim/tb_page_grouped_chunk_fault_resolver_core.sv
